// ===== rtl/b64d_pkg.sv =====
// shared types, constants and character mapping functions for the base64 decoder
// no dependencies
`default_nettype none

package b64d_pkg;

  // default depth of the result queue (power of two, at least 4)
  localparam int unsigned B64D_FIFO_DEPTH = 8;
  // most results one character can cause
  localparam int unsigned B64D_RES_MAX = 3;
  // the padding character '='
  localparam logic [7:0] PAD_CHAR = 8'd61;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_END   = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    status_e    status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } sextet_t;

  // file-name-safe alphabet in ascii order: + 0-9 A-Z _ a-z
  function automatic sextet_t map_safe(logic [7:0] c);
    sextet_t s;
    s = '{hit: 1'b1, value: 6'd0};
    if (c == 8'd43) begin
      s.value = 6'd0;
    end else if (c >= 8'd48 && c <= 8'd57) begin
      s.value = 6'(c - 8'd47);
    end else if (c >= 8'd65 && c <= 8'd90) begin
      s.value = 6'(c - 8'd54);
    end else if (c == 8'd95) begin
      s.value = 6'd37;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      s.value = 6'(c - 8'd59);
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  // standard mime alphabet: A-Z a-z 0-9 + /
  function automatic sextet_t map_mime(logic [7:0] c);
    sextet_t s;
    s = '{hit: 1'b1, value: 6'd0};
    if (c >= 8'd65 && c <= 8'd90) begin
      s.value = 6'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      s.value = 6'(c - 8'd71);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      s.value = 6'(c + 8'd4);
    end else if (c == 8'd43) begin
      s.value = 6'd62;
    end else if (c == 8'd47) begin
      s.value = 6'd63;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64d_in_if.sv =====
// character channel of the base64 decoder: valid/ready plus one encoded character
// no dependencies
`default_nettype none

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/b64d_out_if.sv =====
// result channel of the base64 decoder: valid/ready plus byte, status and last flag
// no dependencies
`default_nettype none

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output data_byte, output status, output last, input ready);
  modport sink   (input valid, input data_byte, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/base64_decoder_two_alphabets_unit.sv =====
// Streaming base64 decoder with two selectable alphabets.
// Input channel in_i: one character per item, last_char flags the end of a message.
// Output channel out_o: one result per item (data byte, end marker or error),
// last flags the final result of a message.
// Config: cfg_we_i/cfg_wdata_i write the alphabet select (0 file-name-safe, 1 mime);
// write it only while the block is idle.
// Each accepted character is decoded in the cycle it is taken; its 0 to 3 results
// land in a result queue of FifoDepth entries and, when the queue held nothing, the
// first of them is offered on out_o in the next cycle.
// Throughput: one character per cycle while in_i.ready is high. The result queue drains
// one result per cycle; a complete quartet pushes three results, which the next three
// characters of the quartet leave time to drain. in_i.ready is high while at least three
// queue entries are free, so the queue depth sets how long the block keeps taking
// characters once out_o stalls; a stalled receiver simply holds the head result on out_o.
// Reset: alphabet select goes to the file-name-safe set, the message state clears
// and the result queue empties. FifoDepth must be a power of two, 4 or more.
`default_nettype none

module base64_decoder_two_alphabets_unit
  import b64d_pkg::*;
#(
  parameter int unsigned FifoDepth = B64D_FIFO_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  b64d_in_if.sink    in_i,
  b64d_out_if.source out_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  // configuration and message state
  logic        alpha_q;
  logic [17:0] acc_q, acc_d;
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  pad_q, pad_d;
  logic        disc_q, disc_d;

  // result queue
  result_t             fifo_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;

  logic        in_acc;
  logic        pop;
  sextet_t     sext;
  result_t     res [B64D_RES_MAX];
  logic [1:0]  push_n;
  logic        fin_en;
  logic [17:0] fin_acc;
  logic [1:0]  fin_pos;
  logic        err;
  logic [23:0] group;

  assign in_i.ready = (cnt_q <= CntW'(FifoDepth - B64D_RES_MAX));
  assign in_acc     = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  // character decode, state update and result build
  always_comb begin
    sext    = alpha_q ? map_mime(in_i.char_code) : map_safe(in_i.char_code);
    group   = {acc_q, sext.value};
    acc_d   = acc_q;
    pos_d   = pos_q;
    pad_d   = pad_q;
    disc_d  = disc_q;
    push_n  = 2'd0;
    fin_en  = 1'b0;
    fin_acc = acc_q;
    fin_pos = pos_q;
    err     = 1'b0;
    for (int k = 0; k < B64D_RES_MAX; k++) begin
      res[k] = '{data_byte: 8'h00, status: ST_DATA, last: 1'b0};
    end

    if (in_acc && !disc_q) begin
      priority if (in_i.char_code == PAD_CHAR) begin
        if (pad_q >= 2'd2) begin
          err = 1'b1;
        end else begin
          pad_d  = pad_q + 2'd1;
          fin_en = in_i.last_char;
        end
      end else if (!sext.hit || pad_q != 2'd0) begin
        err = 1'b1;
      end else if (pos_q == 2'd3) begin
        res[0] = '{data_byte: group[23:16], status: ST_DATA, last: 1'b0};
        res[1] = '{data_byte: group[15:8],  status: ST_DATA, last: 1'b0};
        res[2] = '{data_byte: group[7:0],   status: ST_DATA, last: in_i.last_char};
        push_n = 2'd3;
        acc_d  = '0;
        pos_d  = 2'd0;
      end else begin
        acc_d   = group[17:0];
        pos_d   = pos_q + 2'd1;
        fin_acc = group[17:0];
        fin_pos = pos_q + 2'd1;
        fin_en  = in_i.last_char;
      end
    end

    // leftover of the group at message end
    if (fin_en) begin
      push_n = 2'd1;
      unique case (fin_pos)
        2'd0: res[0] = '{data_byte: 8'h00, status: ST_END, last: 1'b1};
        2'd1: res[0] = '{data_byte: 8'h00, status: ST_ERROR, last: 1'b1};
        2'd2: res[0] = '{data_byte: fin_acc[11:4], status: ST_DATA, last: 1'b1};
        2'd3: begin
          res[0] = '{data_byte: fin_acc[17:10], status: ST_DATA, last: 1'b0};
          res[1] = '{data_byte: fin_acc[9:2],   status: ST_DATA, last: 1'b1};
          push_n = 2'd2;
        end
        default: res[0] = '{data_byte: 8'h00, status: ST_ERROR, last: 1'b1};
      endcase
    end

    // error drops the rest of the message
    if (err) begin
      res[0] = '{data_byte: 8'h00, status: ST_ERROR, last: 1'b1};
      push_n = 2'd1;
      disc_d = 1'b1;
    end

    // any final character clears the message state
    if (in_acc && in_i.last_char) begin
      acc_d  = '0;
      pos_d  = 2'd0;
      pad_d  = 2'd0;
      disc_d = 1'b0;
    end
  end

  assign cnt_d = cnt_q + CntW'(push_n) - CntW'(pop);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= 1'b0;
      acc_q    <= '0;
      pos_q    <= 2'd0;
      pad_q    <= 2'd0;
      disc_q   <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
      acc_q    <= acc_d;
      pos_q    <= pos_d;
      pad_q    <= pad_d;
      disc_q   <= disc_d;
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

  // queue storage, up to three entries written per cycle
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < B64D_RES_MAX; k++) begin
      if (2'(k) < push_n) begin
        fifo_q[wr_ptr_q + PtrW'(k)] <= res[k];
      end
    end
  end

  // head of the queue drives the output
  assign out_o.valid     = (cnt_q != '0);
  assign out_o.data_byte = fifo_q[rd_ptr_q].data_byte;
  assign out_o.status    = fifo_q[rd_ptr_q].status;
  assign out_o.last      = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("result queue count above depth");

  a_room_on_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (cnt_q + CntW'(B64D_RES_MAX) <= CntW'(FifoDepth)))
    else $error("character taken without room for its results");

  a_discard_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && disc_q) |-> (push_n == 2'd0))
    else $error("result pushed while discarding");

  a_error_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0 && res[0].status == ST_ERROR) |-> (res[0].last && push_n == 2'd1))
    else $error("error result not final");

  a_clear_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.last_char) |=> (pos_q == 2'd0 && pad_q == 2'd0 && !disc_q))
    else $error("message state not cleared after final character");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_base64_decoder_two_alphabets_unit.sv =====
// self-checking testbench for base64_decoder_two_alphabets_unit: directed and random messages
// in both alphabets, with a scoreboard that predicts every result and checks it
// depends on rtl/b64d_pkg.sv, rtl/b64d_in_if.sv, rtl/b64d_out_if.sv and the unit itself

import b64d_pkg::*;

// decoder prediction and the store of results still owed by the block
class b64_scoreboard;
  bit          mime_sel;
  bit [17:0]   sextet_acc;
  bit [1:0]    sextet_cnt;
  bit [1:0]    pad_cnt;
  bit          skipping;
  result_t     owed_q[$];
  int unsigned fail_count;

  function void set_alphabet(bit sel);
    mime_sel = sel;
  endfunction

  function void end_message();
    sextet_acc = '0;
    sextet_cnt = '0;
    pad_cnt    = '0;
    skipping   = 1'b0;
  endfunction

  // 64 means the character is not in the selected alphabet
  function int unsigned sextet_of(bit [7:0] c);
    if (mime_sel) begin
      if (c >= 65 && c <= 90) return c - 65;
      if (c >= 97 && c <= 122) return c - 71;
      if (c >= 48 && c <= 57) return c + 4;
      if (c == 43) return 62;
      if (c == 47) return 63;
    end else begin
      if (c == 43) return 0;
      if (c >= 48 && c <= 57) return c - 47;
      if (c >= 65 && c <= 90) return c - 54;
      if (c == 95) return 37;
      if (c >= 97 && c <= 122) return c - 59;
    end
    return 64;
  endfunction

  function void owe(bit [7:0] data, status_e st, bit fin);
    result_t r;
    r.data_byte = data;
    r.status    = st;
    r.last      = fin;
    owed_q.push_back(r);
  endfunction

  // leftover of a partial group at message end
  function void flush_partial();
    case (sextet_cnt)
      2'd0: owe(8'd0, ST_END, 1'b1);
      2'd1: owe(8'd0, ST_ERROR, 1'b1);
      2'd2: owe(sextet_acc[11:4], ST_DATA, 1'b1);
      default: begin
        owe(sextet_acc[17:10], ST_DATA, 1'b0);
        owe(sextet_acc[9:2], ST_DATA, 1'b1);
      end
    endcase
  endfunction

  // note one accepted character; returns 0 when the block just drops it
  function bit note_char(bit [7:0] c, bit fin);
    int unsigned v;
    bit [23:0]   grp;
    if (skipping) begin
      if (fin) end_message();
      return 1'b0;
    end
    v = sextet_of(c);
    if (c == PAD_CHAR) begin
      if (pad_cnt >= 2) begin
        owe(8'd0, ST_ERROR, 1'b1);
      end else begin
        pad_cnt++;
        if (!fin) return 1'b1;
        flush_partial();
      end
    end else if (v == 64 || pad_cnt != 0) begin
      owe(8'd0, ST_ERROR, 1'b1);
    end else if (sextet_cnt == 2'd3) begin
      grp = {sextet_acc, v[5:0]};
      owe(grp[23:16], ST_DATA, 1'b0);
      owe(grp[15:8], ST_DATA, 1'b0);
      owe(grp[7:0], ST_DATA, fin);
      sextet_acc = '0;
      sextet_cnt = '0;
      if (!fin) return 1'b1;
    end else begin
      sextet_acc = {sextet_acc[11:0], v[5:0]};
      sextet_cnt++;
      if (!fin) return 1'b1;
      flush_partial();
    end
    // an error before the final character drops the rest of the message
    if (fin) end_message();
    else skipping = 1'b1;
    return 1'b1;
  endfunction

  function void check_result(logic [7:0] data, logic [1:0] st, logic fin);
    result_t want;
    if (owed_q.size() == 0) begin
      $error("unexpected result: data_byte %0d status %0d last %0d", data, st, fin);
      fail_count++;
      return;
    end
    want = owed_q.pop_front();
    if (data !== want.data_byte) begin
      $error("data_byte mismatch: expected %0d, actual %0d", want.data_byte, data);
      fail_count++;
    end
    if (st !== want.status) begin
      $error("status mismatch: expected %0d, actual %0d", want.status, st);
      fail_count++;
    end
    if (fin !== want.last) begin
      $error("last mismatch: expected %0d, actual %0d", want.last, fin);
      fail_count++;
    end
  endfunction
endclass

module tb_base64_decoder_two_alphabets_unit;

  typedef enum {RX_OPEN, RX_COIN, RX_QUARTER, RX_RARE_STALL} rx_mode_e;
  typedef enum {MSG_CLEAN, MSG_BROKEN, MSG_NOISE} msg_kind_e;

  localparam int unsigned QuietLimit       = 2000;
  localparam int unsigned SettleCycles     = 4;
  localparam int unsigned RandomPhaseChars = 88;
  localparam bit [8:0]    EndMark          = 9'h100;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  b64d_in_if  in_ch ();
  b64d_out_if out_ch ();

  b64_scoreboard sb = new();
  int unsigned   burst_left   = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   phase_chars;

  base64_decoder_two_alphabets_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // character for a sextet value in the chosen alphabet
  function automatic bit [7:0] char_of(bit [5:0] v, bit mime);
    if (mime) begin
      if (v < 26) return 8'(65 + v);
      if (v < 52) return 8'(71 + v);
      if (v < 62) return 8'(v - 4);
      if (v == 62) return 8'd43;
      return 8'd47;
    end
    if (v == 0) return 8'd43;
    if (v < 11) return 8'(47 + v);
    if (v < 37) return 8'(54 + v);
    if (v == 37) return 8'd95;
    return 8'(59 + v);
  endfunction

  // send one character in bursts with random gaps; valid stays up between items of a burst
  task automatic send_char(bit [7:0] c, bit fin, output bit counted);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    counted = sb.note_char(c, fin);
    burst_left--;
  endtask

  task automatic send_list(bit [8:0] seq[]);
    bit counted;
    foreach (seq[i]) send_char(seq[i][7:0], seq[i][8], counted);
  endtask

  // stop sending, let all owed results arrive, then let the block settle
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_alphabet(bit sel);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sel;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_alphabet(sel);
  endtask

  // one message: mostly well formed with random content, some broken, some pure noise
  task automatic send_message();
    bit [7:0]    msg_q[$];
    bit [23:0]   grp;
    int unsigned nbytes;
    int unsigned pads;
    int unsigned pick;
    int unsigned pos;
    msg_kind_e   kind;
    bit          counted;
    pick = $urandom_range(0, 9);
    kind = (pick < 7) ? MSG_CLEAN : (pick < 9) ? MSG_BROKEN : MSG_NOISE;
    if (kind == MSG_NOISE) begin
      repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
      for (int i = 0; i + 3 <= nbytes; i += 3) begin
        grp = $urandom();
        msg_q.push_back(char_of(grp[23:18], sb.mime_sel));
        msg_q.push_back(char_of(grp[17:12], sb.mime_sel));
        msg_q.push_back(char_of(grp[11:6], sb.mime_sel));
        msg_q.push_back(char_of(grp[5:0], sb.mime_sel));
      end
      grp = $urandom();
      case (nbytes % 3)
        1: begin
          msg_q.push_back(char_of(grp[23:18], sb.mime_sel));
          msg_q.push_back(char_of(grp[17:12], sb.mime_sel));
          pads = $urandom_range(0, 2);
        end
        2: begin
          msg_q.push_back(char_of(grp[23:18], sb.mime_sel));
          msg_q.push_back(char_of(grp[17:12], sb.mime_sel));
          msg_q.push_back(char_of(grp[11:6], sb.mime_sel));
          pads = $urandom_range(0, 1);
        end
        default: pads = (nbytes == 0) ? $urandom_range(1, 2) : 0;
      endcase
      repeat (pads) msg_q.push_back(PAD_CHAR);
      // corrupt: random byte, stray pad, or one character too many
      if (kind == MSG_BROKEN) begin
        pos = $urandom_range(0, msg_q.size() - 1);
        case ($urandom_range(0, 2))
          0: msg_q[pos] = 8'($urandom_range(0, 255));
          1: msg_q.insert(pos, PAD_CHAR);
          default: msg_q.push_back(char_of(6'($urandom()), sb.mime_sel));
        endcase
      end
    end
    foreach (msg_q[i]) begin
      send_char(msg_q[i], i == msg_q.size() - 1, counted);
      if (counted) phase_chars++;
    end
  endtask

  // receiver: checks each accepted result, stalls on a mode that changes now and then
  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned tick;
    out_ch.ready <= 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.data_byte, out_ch.status, out_ch.last);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_OPEN:    out_ch.ready <= 1'b1;
        RX_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
        RX_QUARTER: out_ch.ready <= (tick % 4 == 0);
        default:    out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("FAILURE");
    $finish;
  end

  // main sequence
  initial begin
    bit [8:0] safe_seq[];
    bit [8:0] mime_seq[];
    bit       phase_sel[4];
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= 8'd0;
    in_ch.last_char <= 1'b0;
    // range edges of the file-name-safe set, empty end, error then dropped characters
    safe_seq = '{9'd43, 9'd48, 9'd57, 9'd65, 9'd90, 9'd95, 9'd97, EndMark | 9'd122,
                 EndMark | {1'b0, PAD_CHAR}, 9'd123, 9'd0, EndMark | 9'd255};
    // mime: '/' and '+' with two pads, a third pad, a character after a pad, lone sextet
    mime_seq = '{9'd47, 9'd43, {1'b0, PAD_CHAR}, EndMark | {1'b0, PAD_CHAR},
                 9'd48, 9'd57, {1'b0, PAD_CHAR}, {1'b0, PAD_CHAR}, EndMark | {1'b0, PAD_CHAR},
                 9'd122, 9'd90, {1'b0, PAD_CHAR}, EndMark | 9'd97,
                 EndMark | 9'd65};
    phase_sel = '{1'b0, 1'b1, 1'b0, 1'b1};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_alphabet(1'b0);
    send_list(safe_seq);
    drain_and_settle();
    write_alphabet(1'b1);
    send_list(mime_seq);

    foreach (phase_sel[p]) begin
      drain_and_settle();
      write_alphabet(phase_sel[p]);
      phase_chars = 0;
      while (phase_chars < RandomPhaseChars) send_message();
    end
    drain_and_settle();

    if (sb.fail_count == 0 && sb.owed_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/b64d_pkg.sv
rtl/b64d_in_if.sv
rtl/b64d_out_if.sv
rtl/base64_decoder_two_alphabets_unit.sv
tb/tb_base64_decoder_two_alphabets_unit.sv
